// File: design/gctd_pkg.sv
// ----------------------------------------------------------------------------
// gctd_pkg - grow cycle timer and dosing shared definitions
// Item opcodes and configuration register indexes.
// ----------------------------------------------------------------------------
package gctd_pkg;

  // Item opcodes; code 3 is unused and changes nothing
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } gctd_op_e;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TIME_W     = 16;   // width of one on/off/dose time field
  localparam int unsigned NUM_CH     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_TIMES  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_TIMES   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_TIMES    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UV_TIMES     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EC_SETPOINT  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EC_DEADZONE  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DOSE_TIMES   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DOSE_LOCKOUT = 4'd7;

endpackage

// File: design/grow_cycle_timer_and_dosing_core.sv
// ----------------------------------------------------------------------------
// grow_cycle_timer_and_dosing_core - grow cycle timer and nutrient doser
// Four duty-cycle channels (light, pump, air, UV) and a two-pump doser,
// stepped by tick transactions, with start/stop process control.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | in_valid_i/ready_o | opcode_i, ec_sample_i
//  result   | out_valid_o/ready_i| light/pump/air/uv/dose_a/dose_b_on_o,
//           |                    | is_running_o
//  config   | cfg_we_i           | cfg_index_i, cfg_wdata_i
//
// One transaction per cycle while the result is not stalled. The whole state
// update is one pass of small compares and saturating increments; the result
// is registered and shows in the cycle after the input is accepted.
// Reset (rst_ni low) clears all state and configuration registers at once (not the result payload).
// A stalled result holds in the output register; input is still taken in
// the cycle the result leaves (in_ready_o = !out_valid_o || out_ready_i).
// ----------------------------------------------------------------------------
module grow_cycle_timer_and_dosing_core #(
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [gctd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gctd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        opcode_i,
  input  logic [15:0]                       ec_sample_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              light_on_o,
  output logic                              pump_on_o,
  output logic                              air_on_o,
  output logic                              uv_on_o,
  output logic                              dose_a_on_o,
  output logic                              dose_b_on_o,
  output logic                              is_running_o
);

  localparam int unsigned TW    = gctd_pkg::TIME_W;
  localparam int unsigned NCH   = gctd_pkg::NUM_CH;
  localparam int unsigned CNT_W = TIME_BITS + 1;
  // compare width covers both the count and a 16-bit time field
  localparam int unsigned CMP_W = (CNT_W > TW) ? CNT_W : TW;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic reached(input logic [CNT_W-1:0] c, input logic [TW-1:0] t);
    return CMP_W'(c) >= CMP_W'(t);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2*TW-1:0] ch_times_q [NCH];   // on time low half, off time high half
  logic [TW-1:0]   setpoint_q;
  logic [TW-1:0]   deadzone_q;
  logic [2*TW-1:0] dose_times_q;       // pump A low half, pump B high half
  logic [TW-1:0]   lockout_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) begin
        ch_times_q[i] <= '0;
      end
      setpoint_q     <= '0;
      deadzone_q     <= '0;
      dose_times_q   <= '0;
      lockout_time_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gctd_pkg::REG_LIGHT_TIMES:  ch_times_q[0]  <= cfg_wdata_i[2*TW-1:0];
        gctd_pkg::REG_PUMP_TIMES:   ch_times_q[1]  <= cfg_wdata_i[2*TW-1:0];
        gctd_pkg::REG_AIR_TIMES:    ch_times_q[2]  <= cfg_wdata_i[2*TW-1:0];
        gctd_pkg::REG_UV_TIMES:     ch_times_q[3]  <= cfg_wdata_i[2*TW-1:0];
        gctd_pkg::REG_EC_SETPOINT:  setpoint_q     <= cfg_wdata_i[TW-1:0];
        gctd_pkg::REG_EC_DEADZONE:  deadzone_q     <= cfg_wdata_i[TW-1:0];
        gctd_pkg::REG_DOSE_TIMES:   dose_times_q   <= cfg_wdata_i[2*TW-1:0];
        gctd_pkg::REG_DOSE_LOCKOUT: lockout_time_q <= cfg_wdata_i[TW-1:0];
        default: ;  // out-of-range index: ignored
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Process state
  // --------------------------------------------------------------------------
  logic             running_q,  running_d;
  logic             cleanup_q,  cleanup_d;
  logic [NCH-1:0]   ch_on_q,    ch_on_d;
  logic [CNT_W-1:0] ch_cnt_q [NCH];
  logic [CNT_W-1:0] ch_cnt_d [NCH];
  logic [1:0]       dose_on_q,  dose_on_d;
  logic [CNT_W-1:0] dose_cnt_q [2];
  logic [CNT_W-1:0] dose_cnt_d [2];
  logic             lock_q,     lock_d;
  logic [CNT_W-1:0] lock_cnt_q, lock_cnt_d;

  logic in_acc;
  logic out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // signed compare: (sample - deadzone) < setpoint
  logic signed [TW+1:0] ec_diff;
  logic                 dose_req;

  assign ec_diff  = $signed({2'b00, ec_sample_i}) - $signed({2'b00, deadzone_q});
  assign dose_req = ec_diff < $signed({2'b00, setpoint_q});

  always_comb begin
    logic             on_v;
    logic [CNT_W-1:0] cnt_v;
    logic [TW-1:0]    dose_t;

    on_v       = 1'b0;
    cnt_v      = '0;
    dose_t     = '0;
    running_d  = running_q;
    cleanup_d  = cleanup_q;
    ch_on_d    = ch_on_q;
    ch_cnt_d   = ch_cnt_q;
    dose_on_d  = dose_on_q;
    dose_cnt_d = dose_cnt_q;
    lock_d     = lock_q;
    lock_cnt_d = lock_cnt_q;

    case (gctd_pkg::gctd_op_e'(opcode_i))
      gctd_pkg::OP_TICK: begin
        if (running_q) begin
          // duty-cycle channels: off check sees a channel just turned off
          for (int i = 0; i < NCH; i++) begin
            on_v  = ch_on_q[i];
            cnt_v = ch_cnt_q[i];
            if (on_v && reached(cnt_v, ch_times_q[i][TW-1:0])) begin
              on_v  = 1'b0;
              cnt_v = '0;
            end
            if (!on_v && reached(cnt_v, ch_times_q[i][2*TW-1:TW])) begin
              on_v  = 1'b1;
              cnt_v = '0;
            end
            ch_on_d[i]  = on_v;
            ch_cnt_d[i] = sat_inc(cnt_v);
          end

          // doser: start both pumps, arm lockout
          if (dose_req && !lock_q) begin
            dose_on_d = 2'b11;
            lock_d    = 1'b1;
          end
          for (int p = 0; p < 2; p++) begin
            dose_t = (p == 0) ? dose_times_q[TW-1:0] : dose_times_q[2*TW-1:TW];
            cnt_v  = dose_on_d[p] ? sat_inc(dose_cnt_q[p]) : dose_cnt_q[p];
            if (reached(cnt_v, dose_t)) begin
              dose_on_d[p] = 1'b0;
              cnt_v        = '0;
            end
            dose_cnt_d[p] = cnt_v;
          end

          // lockout hold-off
          if (lock_d) begin
            cnt_v = sat_inc(lock_cnt_q);
            if (reached(cnt_v, lockout_time_q)) begin
              cnt_v  = '0;
              lock_d = 1'b0;
            end
            lock_cnt_d = cnt_v;
          end

          cleanup_d = 1'b1;
        end else if (cleanup_q) begin
          // first tick after stop: everything off and cleared
          ch_on_d   = '0;
          dose_on_d = '0;
          lock_d    = 1'b0;
          lock_cnt_d = '0;
          for (int i = 0; i < NCH; i++) begin
            ch_cnt_d[i] = '0;
          end
          for (int p = 0; p < 2; p++) begin
            dose_cnt_d[p] = '0;
          end
          cleanup_d = 1'b0;
        end
      end
      gctd_pkg::OP_START: begin
        ch_on_d   = '1;
        running_d = 1'b1;
      end
      gctd_pkg::OP_STOP: begin
        running_d = 1'b0;
      end
      default: ;  // unused opcode: state unchanged, current state reported
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      cleanup_q  <= 1'b0;
      ch_on_q    <= '0;
      dose_on_q  <= '0;
      lock_q     <= 1'b0;
      lock_cnt_q <= '0;
      for (int i = 0; i < NCH; i++) begin
        ch_cnt_q[i] <= '0;
      end
      for (int p = 0; p < 2; p++) begin
        dose_cnt_q[p] <= '0;
      end
    end else if (in_acc) begin
      running_q  <= running_d;
      cleanup_q  <= cleanup_d;
      ch_on_q    <= ch_on_d;
      dose_on_q  <= dose_on_d;
      lock_q     <= lock_d;
      lock_cnt_q <= lock_cnt_d;
      ch_cnt_q   <= ch_cnt_d;
      dose_cnt_q <= dose_cnt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [NCH-1:0] res_ch_q;
  logic [1:0]     res_dose_q;
  logic           res_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_ch_q   <= ch_on_d;
      res_dose_q <= dose_on_d;
      res_run_q  <= running_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign light_on_o   = res_ch_q[0];
  assign pump_on_o    = res_ch_q[1];
  assign air_on_o     = res_ch_q[2];
  assign uv_on_o      = res_ch_q[3];
  assign dose_a_on_o  = res_dose_q[0];
  assign dose_b_on_o  = res_dose_q[1];
  assign is_running_o = res_run_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // a pending result always mirrors the live state (state moves only on accept)
  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_ch_q == ch_on_q) && (res_dose_q == dose_on_q) &&
                    (res_run_q == running_q))
    else $error("result register out of step with process state");

  // start turns every channel on and sets running
  a_start_sets_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i == gctd_pkg::OP_START) |=> (running_q && (&ch_on_q)))
    else $error("start did not set running and channel outputs");

  // idle and clean: no count left behind
  a_idle_counts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!running_q && !cleanup_q) |->
      (ch_cnt_q[0] == '0) && (ch_cnt_q[1] == '0) && (ch_cnt_q[2] == '0) &&
      (ch_cnt_q[3] == '0) && (dose_cnt_q[0] == '0) && (dose_cnt_q[1] == '0) &&
      !lock_q && (lock_cnt_q == '0) && (dose_on_q == '0))
    else $error("counts not cleared while stopped without pending cleanup");

  // lockout count only runs while the lockout is held
  a_lock_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lock_q |-> (lock_cnt_q == '0))
    else $error("lockout count nonzero with lockout released");

endmodule
